[hdl/lkvt_pkg.sv]
// Shared types and constants for the linear key/value table.
package lkvt_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int KEY_BYTES_DEF = 8;

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_KEY    = 2'd1,
		KIND_VALUE  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	localparam logic signed [VAL_W-1:0] NONE_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		RES_INS_OK,
		RES_FULL,
		RES_MISS,
		RES_HIT
	} res_sel_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     latch;
		logic     wr;
		logic     start;
		logic     step;
		logic     set_res;
		res_sel_t res_sel;
		logic     load_out;
	} lkvt_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  full;
		logic  empty;
		logic  at_end;
		logic  s1_valid;
		logic  hit;
		logic  out_free;
	} lkvt_stat_t;

endpackage

[hdl/lkvt_ctrl.sv]
// Controller state machine for the linear key/value table.
module lkvt_ctrl import lkvt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  lkvt_stat_t stat,
	output lkvt_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if ((stat.kind == KIND_KEY || stat.kind == KIND_VALUE) && !stat.empty) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (stat.hit || (stat.at_end && !stat.s1_valid)) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_sel = RES_MISS;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			S_DECIDE: begin
				unique case (stat.kind)
					KIND_INSERT: begin
						cmd.set_res = 1'b1;
						if (stat.full) begin
							cmd.res_sel = RES_FULL;
						end else begin
							cmd.wr      = 1'b1;
							cmd.res_sel = RES_INS_OK;
						end
					end
					KIND_KEY, KIND_VALUE: begin
						if (stat.empty) begin
							cmd.set_res = 1'b1;
						end else begin
							cmd.start = 1'b1;
						end
					end
					default: cmd.set_res = 1'b1;
				endcase
			end
			S_SCAN: begin
				cmd.step = !stat.at_end && !stat.hit;
				if (stat.hit) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = RES_HIT;
				end else if (stat.at_end && !stat.s1_valid) begin
					cmd.set_res = 1'b1;
				end
			end
			S_DONE: begin
				cmd.load_out = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

[hdl/lkvt_dp.sv]
// Datapath: key/value stores, scan pointer, comparator and result registers.
module lkvt_dp import lkvt_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               kind,
	input  logic [KEY_W-1:0]         key,
	input  logic signed [VAL_W-1:0]  value,
	input  lkvt_cmd_t                cmd,
	output lkvt_stat_t               stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [IDX_W-1:0]         index,
	output logic signed [VAL_W-1:0]  found_value,
	output logic [COUNT_W-1:0]       count
);

	localparam int KB_W = 8 * KEY_BYTES;
	localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);

	logic [KB_W-1:0]  key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];

	logic [KB_W-1:0]  key_norm;
	kind_t            kind_q;
	logic [KB_W-1:0]  key_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic             s1_valid_q;
	logic [CW-1:0]    idx_s1;
	logic [KB_W-1:0]  rd_key_s1;
	logic [VAL_W-1:0] rd_val_s1;
	logic             match;

	logic [STAT_W-1:0]  res_status_q;
	logic [IDX_W-1:0]   res_index_q;
	logic [VAL_W-1:0]   res_fv_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [VAL_W-1:0]   out_fv_q;
	logic [COUNT_W-1:0] out_count_q;

	// keep bytes up to the first zero byte
	always_comb begin
		logic keep;
		keep     = 1'b1;
		key_norm = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			keep = keep && (key[8*b +: 8] != 8'h00);
			if (keep) key_norm[8*b +: 8] = key[8*b +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind_t'(kind);
			key_q  <= key_norm;
			val_q  <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			key_mem[count_q[AW-1:0]] <= key_q;
			val_mem[count_q[AW-1:0]] <= val_q;
		end
		if (cmd.step) begin
			rd_key_s1 <= key_mem[ptr_q[AW-1:0]];
			rd_val_s1 <= val_mem[ptr_q[AW-1:0]];
			idx_s1    <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cmd.wr) count_q <= count_q + CW'(1);
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (cmd.step) begin
				ptr_q <= ptr_q + CW'(1);
			end
			s1_valid_q <= cmd.step;
		end
	end

	assign match = s1_valid_q &&
		((kind_q == KIND_KEY) ? (rd_key_s1 == key_q) : (rd_val_s1 == val_q));

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			unique case (cmd.res_sel)
				RES_INS_OK: begin
					res_status_q <= ST_OK;
					res_index_q  <= IDX_W'(count_q);
					res_fv_q     <= '0;
					res_count_q  <= COUNT_W'(count_q + CW'(1));
				end
				RES_FULL: begin
					res_status_q <= ST_FULL;
					res_index_q  <= '0;
					res_fv_q     <= '0;
					res_count_q  <= COUNT_W'(count_q);
				end
				RES_MISS: begin
					res_status_q <= ST_MISS;
					res_index_q  <= '0;
					res_fv_q     <= NONE_VALUE;
					res_count_q  <= COUNT_W'(count_q);
				end
				RES_HIT: begin
					res_status_q <= ST_OK;
					res_index_q  <= IDX_W'(idx_s1);
					res_fv_q     <= (kind_q == KIND_KEY) ? rd_val_s1 : val_q;
					res_count_q  <= COUNT_W'(count_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_fv_q     <= res_fv_q;
			out_count_q  <= res_count_q;
		end
	end

	assign stat.kind     = kind_q;
	assign stat.full     = (count_q == CW'(ENTRIES));
	assign stat.empty    = (count_q == '0);
	assign stat.at_end   = (ptr_q == count_q);
	assign stat.s1_valid = s1_valid_q;
	assign stat.hit      = match;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign index       = out_index_q;
	assign found_value = out_fv_q;
	assign count       = out_count_q;

endmodule

[hdl/linear_key_value_table.sv]
// Top level of the linear key/value table: controller plus datapath.
//
// Append-only table of key/value pairs, searched from slot 0 upward.
// Input channel (in_valid/in_ready) carries one item: kind, key, value.
//   kind 0 inserts the pair at the next free slot (or reports full),
//   kind 1 looks up by key, kind 2 looks up by value, kind 3 is a no-op miss.
// Keys are normalized: cut to KEY_BYTES bytes, bytes after the first zero cleared.
// Output channel (out_valid/out_ready) returns one result per item:
//   status, index, found_value, count.
// Timing: one item in flight at a time. An insert, a no-op or a lookup on an
//   empty table loads its result without a scan; a lookup scans up from
//   slot 0 and stops at the first hit, and a miss scans all count slots.
//   The next item is accepted the cycle after the result is loaded. The scan
//   reads one slot per cycle through a registered read port and one comparator.
// The output register holds a finished result while the next item is taken;
//   if the receiver stalls, the next result waits inside the block and the
//   input stays blocked until the output register is free.
// Reset clears the entry count and all handshake state; the stores are not
//   cleared, since slots at or above the count are never read.
module linear_key_value_table import lkvt_pkg::*; #(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic [KEY_W-1:0]         key,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic [IDX_W-1:0]         index,
	output logic signed [VAL_W-1:0]  found_value,
	output logic [COUNT_W-1:0]       count
);

	// command and status bundles between controller and datapath
	lkvt_cmd_t  cmd;
	lkvt_stat_t stat;

	lkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores, scan pointer, comparator, result and output registers
	lkvt_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_BYTES (KEY_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.index       (index),
		.found_value (found_value),
		.count       (count)
	);

endmodule

[verif/tb_linear_key_value_table.sv]
// Self-checking testbench for linear_key_value_table: random handshake pacing, scoreboard.
module tb_linear_key_value_table import lkvt_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// No handshake on either side for this many cycles means the block is hung.
	// The slowest correct gap is a full scan plus the longest sender gap and
	// receiver stall (MAX_WAIT each), so this is far above it.
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_WAIT     = 18;

	// One item on the input channel. hold marks an item the sender keeps back
	// until every outstanding result has come out.
	typedef struct packed {
		kind_t                   kind;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic                    hold;
	} request_t;

	// One item on the output channel.
	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] found_value;
		logic [COUNT_W-1:0]      count;
	} answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              kind = KIND_INSERT;
	logic [KEY_W-1:0]        key = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic [IDX_W-1:0]        index;
	logic signed [VAL_W-1:0] found_value;
	logic [COUNT_W-1:0]      count;

	linear_key_value_table uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.index       (index),
		.found_value (found_value),
		.count       (count)
	);

	always #2 clk = ~clk;

	// Stimulus waiting to be driven, and the answers the table must give back.
	request_t queued_requests[$];
	answer_t  awaited_answers[$];

	// Handshake bookkeeping. Each counter has a single writer process.
	int requests_shown = 0;  // driver: items put on the input port
	int requests_taken = 0;  // monitor: items accepted by the block
	int answers_seen   = 0;  // monitor: results accepted from the block
	int answers_acked  = 0;  // receiver: results it has drawn a new stall for
	int total_requests = 0;
	int quiet_cycles   = 0;
	int mismatches     = 0;

	// Predictor state: what the block should hold after every accepted item.
	logic [KEY_W-1:0]        held_key[ENTRIES_DEF];
	logic signed [VAL_W-1:0] held_value[ENTRIES_DEF];
	int                      held_count = 0;

	// Generator shadow of the stored pairs, so that lookups can aim at real
	// entries while the whole stimulus list is built up front.
	logic [KEY_W-1:0]        plan_key[ENTRIES_DEF];
	logic signed [VAL_W-1:0] plan_value[ENTRIES_DEF];
	int                      plan_count = 0;

	// Pacing: each side has a mode, redrawn every 64 items, so that runs
	// without any idling alternate with runs of heavy idling.
	int unsigned send_wait = 0;
	int unsigned send_mode = 0;
	int unsigned recv_wait = 0;
	int unsigned recv_mode = 0;

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	// Keys compare as C strings: keep the low KEY_BYTES bytes up to the
	// first zero byte, clear everything from there on.
	function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] kept;
		bit               ended;
		kept  = '0;
		ended = 1'b0;
		for (int b = 0; b < KEY_BYTES_DEF; b++) begin
			if (raw[8*b +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				kept[8*b +: 8] = raw[8*b +: 8];
		end
		return kept;
	endfunction

	// Apply one accepted item to the predicted table and return its answer.
	function automatic answer_t predict_answer(request_t req);
		answer_t          ans;
		logic [KEY_W-1:0] k;
		bit               hit;
		k               = trim_key(req.key);
		hit             = 1'b0;
		ans.status      = ST_MISS;
		ans.index       = '0;
		ans.found_value = NONE_VALUE;
		case (req.kind)
			KIND_INSERT: begin
				ans.found_value = '0;
				if (held_count >= ENTRIES_DEF) begin
					ans.status = ST_FULL;
				end else begin
					held_key[held_count]   = k;
					held_value[held_count] = req.value;
					ans.status             = ST_OK;
					ans.index              = IDX_W'(held_count);
					held_count++;
				end
			end
			KIND_KEY: begin
				// lowest slot wins, so a duplicate key never shadows the first
				for (int i = 0; i < held_count && !hit; i++) begin
					if (held_key[i] == k) begin
						hit             = 1'b1;
						ans.status      = ST_OK;
						ans.index       = IDX_W'(i);
						ans.found_value = held_value[i];
					end
				end
			end
			KIND_VALUE: begin
				for (int i = 0; i < held_count && !hit; i++) begin
					if (held_value[i] == req.value) begin
						hit             = 1'b1;
						ans.status      = ST_OK;
						ans.index       = IDX_W'(i);
						ans.found_value = req.value;
					end
				end
			end
			default: begin
				// unknown kind: plain miss, table untouched
			end
		endcase
		ans.count = COUNT_W'(held_count);
		return ans;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------------

	function automatic int unsigned draw_wait(int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, MAX_WAIT);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
		endcase
	endfunction

	// Put random junk above the terminating zero byte; the block must ignore it.
	function automatic logic [KEY_W-1:0] add_tail(logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		int               len;
		t   = trim_key(k);
		len = KEY_BYTES_DEF;
		for (int b = KEY_BYTES_DEF - 1; b >= 0; b--)
			if (t[8*b +: 8] == 8'h00)
				len = b;
		for (int b = len + 1; b < 8; b++)
			t[8*b +: 8] = 8'($urandom);
		return t;
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		int               len;
		k = '0;
		case ($urandom_range(0, 3))
			0: k = {$urandom, $urandom};
			1, 2: begin
				// short string; small alphabet so that prefixes and repeats occur
				len = $urandom_range(0, 8);
				for (int b = 0; b < len; b++)
					k[8*b +: 8] = 8'($urandom_range(8'h61, 8'h64));
				if ($urandom_range(0, 1) == 1)
					k = add_tail(k);
			end
			default: begin
				case ($urandom_range(0, 2))
					0: k = '1;
					1: k = '0;
					default: k = {$urandom, $urandom} & ~64'hFF;  // empty string, junk above
				endcase
			end
		endcase
		return k;
	endfunction

	function automatic logic signed [VAL_W-1:0] fresh_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return NONE_VALUE;
			3: return $urandom_range(0, 7);  // small, so equal values repeat
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		logic [KEY_W-1:0] k;
		k = plan_key[$urandom_range(0, plan_count - 1)];
		return ($urandom_range(0, 1) == 1) ? add_tail(k) : k;
	endfunction

	task automatic queue_request(kind_t k, logic [KEY_W-1:0] ky, logic signed [VAL_W-1:0] v,
				     logic hold);
		request_t req;
		req.kind  = k;
		req.key   = ky;
		req.value = v;
		req.hold  = hold;
		queued_requests.push_back(req);
		if (k == KIND_INSERT && plan_count < ENTRIES_DEF) begin
			plan_key[plan_count]   = trim_key(ky);
			plan_value[plan_count] = v;
			plan_count++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Mismatch reporting
	// ---------------------------------------------------------------------

	// One line per mismatch, and a count for the verdict.
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("MISMATCH result %0d %s: got %h, want %h", answers_seen, what, got, want);
	endtask

	// ---------------------------------------------------------------------
	// Driver: input changes on the falling edge only
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		request_t nxt;
		if (arst_n && requests_taken == requests_shown) begin
			// the previous item is gone (or none was shown yet)
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (queued_requests.size() != 0 &&
				     !(queued_requests[0].hold && awaited_answers.size() != 0)) begin
				nxt = queued_requests.pop_front();
				kind     <= nxt.kind;
				key      <= nxt.key;
				value    <= nxt.value;
				in_valid <= 1'b1;
				requests_shown++;
				if (requests_shown % 64 == 0)
					send_mode = $urandom_range(0, 2);
				// gap inserted after this item is taken
				send_wait = draw_wait(send_mode);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: draws a stall for each result, counted only while a result waits
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (answers_seen != answers_acked) begin
				answers_acked = answers_seen;
				if (answers_acked % 64 == 0)
					recv_mode = $urandom_range(0, 2);
				recv_wait = draw_wait(recv_mode);
			end
			out_ready <= (recv_wait == 0);
			if (recv_wait > 0 && out_valid)
				recv_wait--;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: samples both channels on the rising edge, checks, predicts
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		request_t req;
		if (arst_n) begin
			// Output first: a result leaving in the same cycle as a new item
			// is taken belongs to an older item.
			if (out_valid && out_ready) begin
				got.status      = status;
				got.index       = index;
				got.found_value = found_value;
				got.count       = count;
				if (awaited_answers.size() == 0) begin
					report_mismatch("unexpected result", 64'(got), '0);
				end else begin
					want = awaited_answers.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 64'(got.status), 64'(want.status));
					if (got.index !== want.index)
						report_mismatch("index", 64'(got.index), 64'(want.index));
					if (got.found_value !== want.found_value)
						report_mismatch("found_value", 64'(got.found_value),
								64'(want.found_value));
					if (got.count !== want.count)
						report_mismatch("count", 64'(got.count), 64'(want.count));
				end
				answers_seen++;
			end
			if (in_valid && in_ready) begin
				req.kind  = kind_t'(kind);
				req.key   = key;
				req.value = value;
				req.hold  = 1'b0;
				awaited_answers.push_back(predict_answer(req));
				requests_taken++;
			end
			// Watchdog: counts cycles with no handshake at all.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("tb_linear_key_value_table NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus list, reset, and end of run
	// ---------------------------------------------------------------------
	initial begin
		int unsigned roll;
		logic        hold;

		// Empty table: both lookups and the unknown kind must miss.
		queue_request(KIND_KEY,    64'h0,                  32'sh0,         1'b0);
		queue_request(KIND_VALUE,  64'h0,                  NONE_VALUE,     1'b0);
		queue_request(KIND_NONE,   64'hFFFF_FFFF_FFFF_FFFF, NONE_VALUE,    1'b0);
		// Field extremes, the empty string, junk after the terminator, a duplicate.
		queue_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		queue_request(KIND_INSERT, 64'h0,                  32'sh8000_0000, 1'b0);
		queue_request(KIND_INSERT, 64'hDEAD_BEEF_C000_6261, 32'sh0,        1'b0);
		queue_request(KIND_INSERT, 64'h0000_0000_0000_6261, NONE_VALUE,    1'b0);
		queue_request(KIND_KEY,    64'hFFFF_FFFF_FFFF_FFFF, 32'sh0,        1'b0);
		queue_request(KIND_KEY,    64'h0,                  32'sh0,         1'b0);
		// first byte zero: the whole key is the empty string
		queue_request(KIND_KEY,    64'h1234_5678_9ABC_DE00, 32'sh0,        1'b0);
		// duplicate key: the lower slot answers
		queue_request(KIND_KEY,    64'h0000_0000_0000_6261, 32'sh0,        1'b0);
		queue_request(KIND_KEY,    64'hFFFF_FFFF_FF00_6261, 32'sh0,        1'b0);
		// a prefix of a stored key is a different string
		queue_request(KIND_KEY,    64'h0000_0000_0000_0061, 32'sh0,        1'b0);
		// value hit on -1: status OK even though found_value reads like a miss
		queue_request(KIND_VALUE,  64'h0,                  NONE_VALUE,     1'b0);
		queue_request(KIND_VALUE,  64'h0,                  32'sh8000_0000, 1'b0);
		queue_request(KIND_VALUE,  64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		queue_request(KIND_VALUE,  64'h0,                  32'sh0,         1'b0);
		queue_request(KIND_VALUE,  64'h0,                  32'sh1,         1'b0);
		// sender holds this one back until all results are out
		queue_request(KIND_NONE,   64'h0,                  32'sh0,         1'b1);
		queue_request(KIND_INSERT, 64'h0000_0000_0000_00FF, 32'sh1,        1'b0);
		queue_request(KIND_KEY,    64'hAAAA_AAAA_AAAA_00FF, 32'sh0,        1'b0);

		// Random part: mostly lookups aimed at stored entries. Inserts fill
		// the table early on, after which they exercise the full answer.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			hold = (n % 250 == 125);
			if (roll < 12) begin
				queue_request(KIND_INSERT,
					(plan_count > 0 && $urandom_range(0, 9) < 3) ? stored_key() : fresh_key(),
					(plan_count > 0 && $urandom_range(0, 9) < 3) ?
						plan_value[$urandom_range(0, plan_count - 1)] : fresh_value(),
					hold);
			end else if (roll < 57) begin
				queue_request(KIND_KEY,
					(plan_count > 0 && $urandom_range(0, 9) < 7) ? stored_key() : fresh_key(),
					$urandom, hold);
			end else if (roll < 95) begin
				queue_request(KIND_VALUE, {$urandom, $urandom},
					(plan_count > 0 && $urandom_range(0, 99) < 65) ?
						plan_value[$urandom_range(0, plan_count - 1)] : fresh_value(),
					hold);
			end else begin
				queue_request(KIND_NONE, {$urandom, $urandom}, $urandom, hold);
			end
		end
		total_requests = queued_requests.size();

		// Reset held, then released away from the sampling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (requests_taken != total_requests)
			@(posedge clk);
		while (awaited_answers.size() != 0)
			@(posedge clk);
		// let any stray extra result show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb_linear_key_value_table OK");
		else
			$display("tb_linear_key_value_table NOT OK");
		$finish;
	end

endmodule
